@@ src/tsts_pkg.sv @@
// ----------------------------------------------------------------------------
// tsts_pkg
// Types, codes and helpers shared by the timer slot table scheduler.
// ----------------------------------------------------------------------------
package tsts_pkg;

  localparam int TOPIC_COUNT = 16;
  localparam int OWNER_COUNT = 16;

  localparam logic [30:0] TMO_NONE = 31'h7FFF_FFFF;

  localparam logic REQ_TICK = 1'b0;
  localparam logic REQ_ADD  = 1'b1;

  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_FULL = 2'd1;
  localparam logic [1:0] STAT_ZERO = 2'd2;

  typedef struct packed {
    logic [30:0] dur;
    logic [30:0] rem;
    logic        per;
    logic [3:0]  topic;
    logic [3:0]  owner;
  } slot_t;

  typedef struct packed {
    logic start;
    logic step;
    logic load_sum;
  } ctrl_cmd_t;

  typedef struct packed {
    logic need_out;
    logic out_free;
    logic last_slot;
  } dp_stat_t;

  function automatic logic [3:0] clamp_topic(input logic [3:0] id);
    if (int'(id) >= TOPIC_COUNT) begin
      return 4'(TOPIC_COUNT - 1);
    end
    return id;
  endfunction

  function automatic logic [3:0] clamp_owner(input logic [3:0] id);
    if (int'(id) >= OWNER_COUNT) begin
      return 4'(OWNER_COUNT - 1);
    end
    return id;
  endfunction

endpackage

@@ src/tsts_ctrl.sv @@
// ----------------------------------------------------------------------------
// tsts_ctrl
// Sequencer: take a request, sweep slots one per cycle unless held, summarize.
// ----------------------------------------------------------------------------
module tsts_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  tsts_pkg::dp_stat_t    stat,
  output tsts_pkg::ctrl_cmd_t   cmd
);
  import tsts_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SWEEP = 3'b010,
    ST_SUM   = 3'b100
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.start  = 1'b1;
          state_next = ST_SWEEP;
        end
      end
      ST_SWEEP: begin
        // hold while an expiry item waits for the output register
        if (!stat.need_out || stat.out_free) begin
          cmd.step = 1'b1;
          if (stat.last_slot) begin
            state_next = ST_SUM;
          end
        end
      end
      ST_SUM: begin
        if (stat.out_free) begin
          cmd.load_sum = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

@@ src/tsts_dpath.sv @@
// ----------------------------------------------------------------------------
// tsts_dpath
// Slot memory, active bits, aging arithmetic, running minimum and output
// register.
// ----------------------------------------------------------------------------
module tsts_dpath #(
  parameter int TIMER_SLOTS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  tsts_pkg::ctrl_cmd_t   cmd,
  output tsts_pkg::dp_stat_t    stat,
  input  logic                  req_type,
  input  logic [30:0]           elapsed_ms,
  input  logic [30:0]           new_duration_ms,
  input  logic                  new_periodic,
  input  logic [3:0]            new_topic,
  input  logic [3:0]            new_owner,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  is_expiry,
  output logic [3:0]            expired_topic,
  output logic [3:0]            expired_owner,
  output logic [1:0]            add_status,
  output logic                  next_valid,
  output logic [30:0]           next_timeout_ms,
  output logic                  last
);
  import tsts_pkg::*;

  localparam int IDX_W = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
  localparam int CNT_W = $clog2(TIMER_SLOTS + 1);

  slot_t                  mem [TIMER_SLOTS];
  slot_t                  rdata;
  slot_t                  new_slot;
  slot_t                  cur;
  slot_t                  wdata;
  logic [TIMER_SLOTS-1:0] active;
  logic [CNT_W-1:0]       count;
  logic [IDX_W-1:0]       idx;
  logic [IDX_W-1:0]       rd_addr;
  logic                   rd_en;
  logic [30:0]            elapsed;
  logic [1:0]             status;
  logic                   age;
  logic                   add_pend;
  logic [30:0]            shortest;
  logic                   found;

  logic [1:0]             status_next;
  logic                   place;
  logic                   cur_act;
  logic [31:0]            diff;
  logic                   expire;
  logic                   keep;
  logic                   freed;
  logic [30:0]            rem_new;
  logic                   out_free;

  // request decode at accept
  always_comb begin
    status_next = STAT_OK;
    if (req_type == REQ_ADD) begin
      if (new_duration_ms == '0) begin
        status_next = STAT_ZERO;
      end else if (count == CNT_W'(TIMER_SLOTS)) begin
        status_next = STAT_FULL;
      end
    end
  end

  // per-slot aging
  always_comb begin
    place   = add_pend && !active[idx];
    cur_act = active[idx] || place;
    cur     = place ? new_slot : rdata;
    diff    = {1'b0, cur.rem} - {1'b0, elapsed};
    expire  = cur_act && age && (diff[31] || (diff == '0));
    freed   = expire && !cur.per;
    keep    = cur_act && !freed;
    if (!age) begin
      rem_new = cur.rem;
    end else if (expire) begin
      rem_new = cur.dur;
    end else begin
      rem_new = diff[30:0];
    end
    wdata     = cur;
    wdata.rem = rem_new;
  end

  assign out_free       = !out_valid || out_ready;
  assign stat.need_out  = expire;
  assign stat.out_free  = out_free;
  assign stat.last_slot = (idx == IDX_W'(TIMER_SLOTS - 1));

  assign rd_en   = cmd.start || (cmd.step && !stat.last_slot);
  assign rd_addr = cmd.start ? '0 : idx + 1'b1;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
    if (cmd.step && keep) begin
      mem[idx] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      elapsed        <= elapsed_ms;
      new_slot.dur   <= new_duration_ms;
      new_slot.rem   <= new_duration_ms;
      new_slot.per   <= new_periodic;
      new_slot.topic <= clamp_topic(new_topic);
      new_slot.owner <= clamp_owner(new_owner);
      status         <= status_next;
      age            <= (status_next == STAT_OK);
      shortest       <= TMO_NONE;
    end else if (cmd.step && keep && (rem_new <= shortest)) begin
      shortest <= rem_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active   <= '0;
      count    <= '0;
      idx      <= '0;
      add_pend <= 1'b0;
      found    <= 1'b0;
    end else if (cmd.start) begin
      idx      <= '0;
      add_pend <= (req_type == REQ_ADD) && (status_next == STAT_OK);
      found    <= 1'b0;
    end else if (cmd.step) begin
      idx         <= idx + 1'b1;
      active[idx] <= keep;
      if (place) begin
        add_pend <= 1'b0;
      end
      if (place && !freed) begin
        count <= count + 1'b1;
      end else if (!place && freed) begin
        count <= count - 1'b1;
      end
      if (keep) begin
        found <= 1'b1;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((cmd.step && expire) || cmd.load_sum) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step && expire) begin
      is_expiry       <= 1'b1;
      expired_topic   <= cur.topic;
      expired_owner   <= cur.owner;
      add_status      <= status;
      next_valid      <= 1'b0;
      next_timeout_ms <= '0;
      last            <= 1'b0;
    end else if (cmd.load_sum) begin
      is_expiry       <= 1'b0;
      expired_topic   <= '0;
      expired_owner   <= '0;
      add_status      <= status;
      next_valid      <= found;
      next_timeout_ms <= shortest;
      last            <= 1'b1;
    end
  end

endmodule

@@ src/timer_slot_table_scheduler.sv @@
// ----------------------------------------------------------------------------
// timer_slot_table_scheduler
// Timer slot table: add timers, age all slots, report expiries and the
// shortest remaining time.
//
//   channel  direction  handshake            payload
//   in       input      in_valid / in_ready  req_type, elapsed_ms,
//                                            new_duration_ms, new_periodic,
//                                            new_topic, new_owner
//   out      output     out_valid/out_ready  is_expiry, expired_topic,
//                                            expired_owner, add_status,
//                                            next_valid, next_timeout_ms, last
//
// An item is handled in steps: accept it and read slot 0, then step through
// every slot of the slot memory (one read and one write per slot), then emit
// the summary.
// The sweep stalls on an expiry item for as long as the output register stays
// full. in_ready is high only between items; the summary may still wait in
// the output register while the next item is accepted.
// Reset clears the active bits and the slot count; slot memory is not
// cleared.
// ----------------------------------------------------------------------------
module timer_slot_table_scheduler #(
  parameter int TIMER_SLOTS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        req_type,
  input  logic [30:0] elapsed_ms,
  input  logic [30:0] new_duration_ms,
  input  logic        new_periodic,
  input  logic [3:0]  new_topic,
  input  logic [3:0]  new_owner,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        is_expiry,
  output logic [3:0]  expired_topic,
  output logic [3:0]  expired_owner,
  output logic [1:0]  add_status,
  output logic        next_valid,
  output logic [30:0] next_timeout_ms,
  output logic        last
);
  import tsts_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  tsts_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  tsts_dpath #(
    .TIMER_SLOTS (TIMER_SLOTS)
  ) u_dpath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .req_type        (req_type),
    .elapsed_ms      (elapsed_ms),
    .new_duration_ms (new_duration_ms),
    .new_periodic    (new_periodic),
    .new_topic       (new_topic),
    .new_owner       (new_owner),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .is_expiry       (is_expiry),
    .expired_topic   (expired_topic),
    .expired_owner   (expired_owner),
    .add_status      (add_status),
    .next_valid      (next_valid),
    .next_timeout_ms (next_timeout_ms),
    .last            (last)
  );

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("in_ready high right after accept");

  a_expiry_xor_last: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (is_expiry != last))
    else $error("item is neither expiry nor summary");

  a_expiry_no_timeout: assert property (@(posedge clk) disable iff (rst)
    (out_valid && is_expiry) |-> (!next_valid && (next_timeout_ms == '0)))
    else $error("expiry item carries summary fields");

  a_idle_timeout: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !is_expiry && !next_valid) |-> (next_timeout_ms == TMO_NONE))
    else $error("empty table summary timeout wrong");

  a_cmd_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0(cmd))
    else $error("controller issued overlapping commands");
`endif

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the timer slot table scheduler: drives add and tick
// requests, predicts expiry notices and summaries from a private slot table,
// and compares every output item in order.
// ----------------------------------------------------------------------------
module tb;
  import tsts_pkg::*;

  localparam int SLOTS       = 16;
  localparam int STALL_LIMIT = 2000;
  localparam int IDLE_PCT    = 13;

  typedef struct packed {
    logic        is_exp;
    logic [3:0]  topic;
    logic [3:0]  owner;
    logic [1:0]  status;
    logic        nv;
    logic [30:0] tmo;
    logic        fin;
  } timer_note_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        req_type = REQ_TICK;
  logic [30:0] elapsed_ms = '0;
  logic [30:0] new_duration_ms = '0;
  logic        new_periodic = 1'b0;
  logic [3:0]  new_topic = '0;
  logic [3:0]  new_owner = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        is_expiry;
  logic [3:0]  expired_topic;
  logic [3:0]  expired_owner;
  logic [1:0]  add_status;
  logic        next_valid;
  logic [30:0] next_timeout_ms;
  logic        last;

  logic [30:0] tbl_dur [SLOTS];
  longint      tbl_rem [SLOTS];
  logic        tbl_per [SLOTS];
  logic [3:0]  tbl_topic [SLOTS];
  logic [3:0]  tbl_owner [SLOTS];

  timer_note_t pending_notes[$];
  int          mismatches = 0;
  int          idle_cycles = 0;
  bit          steady = 1'b0;

  timer_slot_table_scheduler DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .req_type(req_type),
    .elapsed_ms(elapsed_ms),
    .new_duration_ms(new_duration_ms),
    .new_periodic(new_periodic),
    .new_topic(new_topic),
    .new_owner(new_owner),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .is_expiry(is_expiry),
    .expired_topic(expired_topic),
    .expired_owner(expired_owner),
    .add_status(add_status),
    .next_valid(next_valid),
    .next_timeout_ms(next_timeout_ms),
    .last(last)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic void compute_timer_notes(input logic req, input logic [30:0] el,
                                              input logic [30:0] dur, input logic per,
                                              input logic [3:0] top, input logic [3:0] own);
    logic [1:0]  status;
    bit          age;
    int          free_slot;
    longint      shortest;
    bit          any_running;
    timer_note_t note;
    status = STAT_OK;
    age = 1'b1;
    free_slot = -1;
    shortest = longint'(TMO_NONE);
    any_running = 1'b0;
    if (req == REQ_ADD) begin
      if (dur == '0) begin
        status = STAT_ZERO;
        age = 1'b0;
      end else begin
        for (int i = SLOTS - 1; i >= 0; i--) begin
          if (tbl_dur[i] == '0) free_slot = i;
        end
        if (free_slot < 0) begin
          status = STAT_FULL;
          age = 1'b0;
        end else begin
          tbl_dur[free_slot] = dur;
          tbl_rem[free_slot] = longint'(dur);
          tbl_per[free_slot] = per;
          tbl_topic[free_slot] = (int'(top) >= TOPIC_COUNT) ? 4'(TOPIC_COUNT - 1) : top;
          tbl_owner[free_slot] = (int'(own) >= OWNER_COUNT) ? 4'(OWNER_COUNT - 1) : own;
        end
      end
    end
    for (int i = 0; i < SLOTS; i++) begin
      if (tbl_dur[i] != '0) begin
        if (age) begin
          tbl_rem[i] -= longint'(el);
          if (tbl_rem[i] <= 0) begin
            note = '{1'b1, tbl_topic[i], tbl_owner[i], status, 1'b0, 31'd0, 1'b0};
            pending_notes.push_back(note);
            if (tbl_per[i]) begin
              tbl_rem[i] = longint'(tbl_dur[i]);
            end else begin
              tbl_dur[i] = '0;
              tbl_rem[i] = 0;
              tbl_per[i] = 1'b0;
              tbl_topic[i] = '0;
              tbl_owner[i] = '0;
            end
          end
        end
        if (tbl_dur[i] != '0 && tbl_rem[i] > 0 && tbl_rem[i] <= shortest) begin
          shortest = tbl_rem[i];
          any_running = 1'b1;
        end
      end
    end
    note = '{1'b0, 4'd0, 4'd0, status, any_running, 31'(shortest), 1'b1};
    pending_notes.push_back(note);
  endfunction

  task automatic send_req(input logic req, input logic [30:0] el, input logic [30:0] dur,
                          input logic per, input logic [3:0] top, input logic [3:0] own);
    if (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < IDLE_PCT) @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= req;
    elapsed_ms <= el;
    new_duration_ms <= dur;
    new_periodic <= per;
    new_topic <= top;
    new_owner <= own;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    compute_timer_notes(req, el, dur, per, top, own);
  endtask

  task automatic send_random_req();
    logic [30:0] el;
    logic [30:0] dur;
    int          pick;
    pick = $urandom_range(99);
    if (pick < 8) dur = '0;
    else if (pick < 14) dur = 31'($urandom());
    else dur = 31'($urandom_range(300, 1));
    pick = $urandom_range(99);
    if (pick < 6) el = '0;
    else if (pick < 10) el = TMO_NONE;
    else if (pick < 16) el = 31'($urandom());
    else el = 31'($urandom_range(60));
    send_req(logic'($urandom_range(1)), el, dur, ($urandom_range(99) < 6),
             4'($urandom_range(15)), 4'($urandom_range(15)));
  endtask

  task automatic test_directed();
    send_req(REQ_TICK, 31'd0, 31'd0, 1'b0, 4'd0, 4'd0);
    send_req(REQ_TICK, TMO_NONE, TMO_NONE, 1'b1, 4'd15, 4'd15);
    send_req(REQ_ADD, 31'd5, 31'd0, 1'b1, 4'd3, 4'd4);
    send_req(REQ_ADD, 31'd0, TMO_NONE, 1'b1, 4'd15, 4'd15);
    send_req(REQ_ADD, 31'd1, 31'd1, 1'b0, 4'd1, 4'd2);
    send_req(REQ_ADD, 31'd0, 31'd5, 1'b1, 4'd6, 4'd7);
    send_req(REQ_TICK, TMO_NONE, 31'd0, 1'b0, 4'd0, 4'd0);
    send_req(REQ_ADD, 31'd10, 31'd10, 1'b0, 4'd8, 4'd9);
    for (int i = 0; i < SLOTS - 2; i++) begin
      send_req(REQ_ADD, 31'd0, 31'(1000 + i), 1'b0, 4'(i), 4'(15 - i));
    end
    send_req(REQ_ADD, 31'd3, 31'd77, 1'b1, 4'd2, 4'd2);
    send_req(REQ_ADD, 31'd3, 31'd0, 1'b0, 4'd5, 4'd5);
    send_req(REQ_TICK, TMO_NONE, 31'd0, 1'b0, 4'd0, 4'd0);
  endtask

  task automatic test_random_traffic(input int count);
    steady = 1'b0;
    repeat (count) send_random_req();
  endtask

  task automatic test_back_to_back(input int count);
    steady = 1'b1;
    repeat (count) send_random_req();
    steady = 1'b0;
  endtask

  task automatic check_result();
    timer_note_t want;
    timer_note_t got;
    got = {is_expiry, expired_topic, expired_owner, add_status, next_valid, next_timeout_ms,
           last};
    if (pending_notes.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("unexpected item: exp=%0d topic=%0d owner=%0d st=%0d nv=%0d tmo=%0d last=%0d",
                 got.is_exp, got.topic, got.owner, got.status, got.nv, got.tmo, got.fin);
      end
    end else begin
      want = pending_notes.pop_front();
      if (got.is_exp !== want.is_exp || got.topic !== want.topic ||
          got.owner !== want.owner || got.status !== want.status ||
          got.nv !== want.nv || got.tmo !== want.tmo || got.fin !== want.fin) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch at %0t", $realtime);
          $display("  expected exp=%0d topic=%0d owner=%0d st=%0d nv=%0d tmo=%0d last=%0d",
                   want.is_exp, want.topic, want.owner, want.status, want.nv, want.tmo,
                   want.fin);
          $display("  actual   exp=%0d topic=%0d owner=%0d st=%0d nv=%0d tmo=%0d last=%0d",
                   got.is_exp, got.topic, got.owner, got.status, got.nv, got.tmo, got.fin);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) check_result();
    out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      tbl_dur[i] = '0;
      tbl_rem[i] = 0;
      tbl_per[i] = 1'b0;
      tbl_topic[i] = '0;
      tbl_owner[i] = '0;
    end
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random_traffic(235);
    test_back_to_back(120);
    in_valid <= 1'b0;
    while (pending_notes.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ sim.f @@
src/tsts_pkg.sv
src/tsts_ctrl.sv
src/tsts_dpath.sv
src/timer_slot_table_scheduler.sv
bench/tb.sv
